// ----- sv/lps_pkg.sv -----
// Shared types and defaults for the line pixel stepper.
`default_nettype none

package lps_pkg;

  // Default coordinate width in bits.
  localparam int unsigned COORD_BITS_DEF = 6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // Capture the endpoints of an accepted beat.
    logic setup;  // Derive spans, direction and the initial decision value.
    logic fill;   // Step the line and write one minor coordinate.
    logic emit;   // Read the buffer back and present points.
  } lps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_last;  // The current fill step writes the final entry.
    logic emit_last;  // The final point moves into the output register.
  } lps_status_t;

endpackage

`default_nettype wire

// ----- sv/lps_ram.sv -----
// Generic simple dual-port RAM with a registered read.
`default_nettype none

module lps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/lps_ctrl.sv -----
// Controller state machine that sequences load, setup, fill and emit.
`default_nettype none

module lps_ctrl
  import lps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire lps_status_t status,
  output lps_cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_FILL  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_FILL;
      end
      ST_FILL: begin
        cmd.fill = 1'b1;
        if (status.fill_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/lps_datapath.sv -----
// Datapath: endpoint setup, decision stepping, buffer and output register.
`default_nettype none

module lps_datapath
  import lps_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire lps_cmd_t                              cmd,
  output lps_status_t                                status,
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  output logic      [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,
  output logic                                       m_tlast
);

  localparam int unsigned W     = COORD_BITS;
  localparam int unsigned OUT_W = ((2*W+7)/8)*8;
  localparam int unsigned DEPTH = 1 << W;

  // Captured endpoints.
  logic [W-1:0] x0, y0, x1, y1;

  // Per-line values set up once.
  logic         by_x, reverse, step_neg;
  logic [W-1:0] ma, dm, dn;

  // Fill-phase state.
  logic [W-1:0]        minor, j;
  logic signed [W+2:0] dec;

  // Emit-phase state.
  logic         rd_more, p1_valid;
  logic [W-1:0] rd_idx, p1_idx;
  logic [W-1:0] px, py;

  // Setup arithmetic.
  logic signed [W:0]   dx, dy, ndx, ndy, dmin;
  logic [W-1:0]        adx, ady;
  logic                by_x_n, rev_n, min_pos;
  logic signed [W+2:0] dec_init, dec_minor, dec_flat;
  logic                dec_pos;

  // Emit control.
  logic         out_free, advance, issue;
  logic [W-1:0] idx_sel, raddr, k_p1, major, rdata;

  assign dx  = $signed({x1[W-1], x1}) - $signed({x0[W-1], x0});
  assign dy  = $signed({y1[W-1], y1}) - $signed({y0[W-1], y0});
  assign ndx = -dx;
  assign ndy = -dy;
  assign adx = dx[W] ? ndx[W-1:0] : dx[W-1:0];
  assign ady = dy[W] ? ndy[W-1:0] : dy[W-1:0];

  // Row axis is major on equal spans; a backward major axis is stepped from the end.
  assign by_x_n  = ady < adx;
  assign rev_n   = by_x_n ? dx[W] : dy[W];
  assign dmin    = by_x_n ? dy : dx;
  assign min_pos = !dmin[W] && (dmin != '0);

  assign dec_init  = $signed({2'b00, (by_x_n ? ady : adx), 1'b0})
                   - $signed({3'b000, (by_x_n ? adx : ady)});
  assign dec_minor = $signed({2'b00, dn, 1'b0}) - $signed({2'b00, dm, 1'b0});
  assign dec_flat  = $signed({2'b00, dn, 1'b0});
  assign dec_pos   = !dec[W+2] && (dec != '0);

  // Endpoint capture and line setup.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0 <= s_tdata[W-1:0];
      y0 <= s_tdata[2*W-1:W];
      x1 <= s_tdata[3*W-1:2*W];
      y1 <= s_tdata[4*W-1:3*W];
    end
    if (cmd.setup) begin
      by_x     <= by_x_n;
      reverse  <= rev_n;
      dm       <= by_x_n ? adx : ady;
      dn       <= by_x_n ? ady : adx;
      ma       <= by_x_n ? (rev_n ? x1 : x0) : (rev_n ? y1 : y0);
      minor    <= by_x_n ? (rev_n ? y1 : y0) : (rev_n ? x1 : x0);
      step_neg <= rev_n ? min_pos : dmin[W];
      dec      <= dec_init;
      j        <= '0;
    end else if (cmd.fill) begin
      // One major step: the minor coordinate moves when the decision is positive.
      if (dec_pos) begin
        minor <= step_neg ? minor - W'(1) : minor + W'(1);
        dec   <= dec + dec_minor;
      end else begin
        dec <= dec + dec_flat;
      end
      j <= j + W'(1);
    end
  end

  assign status.fill_last = cmd.fill && (j == dm);

  // Read index selection: hold the pending address while the output is stalled.
  assign out_free = !m_tvalid || m_tready;
  assign advance  = cmd.emit && out_free;
  assign issue    = advance && rd_more;
  assign idx_sel  = advance ? rd_idx : p1_idx;
  assign raddr    = reverse ? dm - idx_sel : idx_sel;
  assign k_p1     = reverse ? dm - p1_idx : p1_idx;
  assign major    = ma + k_p1;

  assign status.emit_last = advance && p1_valid && (p1_idx == dm);

  lps_ram #(
    .WIDTH (W),
    .DEPTH (DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (cmd.fill),
    .waddr (j),
    .wdata (minor),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Read pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      rd_more  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.setup) begin
        p1_valid <= 1'b0;
        rd_more  <= 1'b1;
      end else if (advance) begin
        p1_valid <= issue;
        if (issue && (rd_idx == dm)) begin
          rd_more <= 1'b0;
        end
      end
      if (advance && p1_valid) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Read indexes and output payload.
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      rd_idx <= '0;
    end else if (issue) begin
      rd_idx <= rd_idx + W'(1);
    end
    if (advance) begin
      p1_idx <= rd_idx;
    end
    if (advance && p1_valid) begin
      px      <= by_x ? major : rdata;
      py      <= by_x ? rdata : major;
      m_tlast <= (p1_idx == dm);
    end
  end

  assign m_tdata = OUT_W'({py, px});

  // The final point reaches the output as the last beat.
  a_last_out : assert property (@(posedge clk) disable iff (rst)
    status.emit_last |=> (m_tvalid && m_tlast))
    else $error("final point did not reach the output as the last beat");

  // Filling never writes past the major span.
  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    cmd.fill |-> (j <= dm))
    else $error("fill index ran past the major span");

  // No read is issued after the final index.
  a_no_overread : assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && !rd_more) |-> !issue)
    else $error("buffer read issued after the final index");

endmodule

`default_nettype wire

// ----- sv/line_pixel_stepper.sv -----
// Top level of the line pixel stepper.
//
// Takes two signed endpoints per input beat and emits every pixel of the
// Bresenham line from the first endpoint to the second, both included, one
// pixel per output beat, with tlast on the second endpoint. The major axis
// is the one with the larger span (the row axis on equal spans); a line whose
// major axis runs backward is stepped from the second endpoint and read back
// in reverse. Each line goes through a setup step, then one buffer write per
// pixel while stepping, then one buffer read per pixel through the registered
// read port of the 2^COORD_BITS-entry minor coordinate buffer, with reads held
// while the output stalls. A new beat is taken once the final pixel sits in the
// output register, even while it still waits to be taken.
`default_nettype none

module line_pixel_stepper
  import lps_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // start_x, start_y, end_x, end_y from the lowest bit up.
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // point_x, point_y from the lowest bit up.
  output logic      [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,
  // last_point.
  output logic                                       m_tlast
);

  lps_cmd_t    cmd;
  lps_status_t status;

  lps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lps_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
